// ===== sv/ffba_pkg.sv =====
// ffba_pkg: shared constants, codes and types for the first-fit block allocator.
// No dependencies; imported by the cells and the top level.
`default_nettype none
package ffba_pkg;

	localparam int MAX_BLOCKS_DEF = 64;
	localparam int ADDR_BITS_DEF  = 40;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOFIT    = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	// per-cell action codes
	localparam logic [3:0] ACT_HOLD      = 4'd0;
	localparam logic [3:0] ACT_INIT      = 4'd1;
	localparam logic [3:0] ACT_MATCH     = 4'd2;
	localparam logic [3:0] ACT_TAKE_PREV = 4'd3;
	localparam logic [3:0] ACT_TAKE_NEXT = 4'd4;
	localparam logic [3:0] ACT_SPLIT_REM = 4'd5;
	localparam logic [3:0] ACT_ALLOC     = 4'd6;
	localparam logic [3:0] ACT_MARK_FREE = 4'd7;
	localparam logic [3:0] ACT_ABSORB    = 4'd8;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MATCH = 3'd1;
	localparam logic [2:0] S_ACT   = 3'd2;
	localparam logic [2:0] S_MERGE = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	typedef struct packed {
		logic valid;
		logic free;
		logic hit;
		logic gt;
		logic pair;
	} cell_flags_t;

endpackage
`default_nettype wire

// ===== sv/ffba_if.sv =====
// ffba_req_if / ffba_rsp_if: valid/ready channels for requests and results.
// Width follows ADDR_BITS; no other dependencies.
`default_nettype none
interface ffba_req_if #(parameter int ADDR_BITS = 40);
	logic                 valid;
	logic                 ready;
	logic                 func;
	logic [ADDR_BITS:0]   req_size;
	logic [ADDR_BITS-1:0] free_offset;
	modport source (output valid, func, req_size, free_offset, input ready);
	modport sink (input valid, func, req_size, free_offset, output ready);
endinterface

interface ffba_rsp_if #(parameter int ADDR_BITS = 40);
	logic                 valid;
	logic                 ready;
	logic [ADDR_BITS-1:0] alloc_offset;
	logic [1:0]           status;
	logic [ADDR_BITS:0]   used_bytes;
	modport source (output valid, alloc_offset, status, used_bytes, input ready);
	modport sink (input valid, alloc_offset, status, used_bytes, output ready);
endinterface
`default_nettype wire

// ===== sv/ffba_cell.sv =====
// ffba_cell: one table entry (offset, size, free mark) of the block chain.
// Uses ffba_pkg; exchanges its entry with both neighbors.
`default_nettype none
module ffba_cell #(
	parameter int  ADDR_BITS = 40,
	parameter bit  IS_HEAD   = 1'b0
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [3:0]            act,
	input  wire logic                  func,
	input  wire logic [ADDR_BITS:0]    req,
	input  wire logic [ADDR_BITS-1:0]  ofs,
	input  wire logic [ADDR_BITS:0]    budget,
	input  wire ffba_pkg::cell_flags_t prev_flags,
	input  wire logic [ADDR_BITS-1:0]  prev_off,
	input  wire logic [ADDR_BITS:0]    prev_size,
	input  wire ffba_pkg::cell_flags_t next_flags,
	input  wire logic [ADDR_BITS-1:0]  next_off,
	input  wire logic [ADDR_BITS:0]    next_size,
	output ffba_pkg::cell_flags_t      flags,
	output logic [ADDR_BITS-1:0]       off,
	output logic [ADDR_BITS:0]         size
);
	import ffba_pkg::*;

	logic              valid_q, free_q, hit_q, gt_q;
	logic [ADDR_BITS-1:0] off_q;
	logic [ADDR_BITS:0]   size_q;
	logic [ADDR_BITS:0]   rem_off;

	assign rem_off = {1'b0, prev_off} + req;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= IS_HEAD;
			free_q  <= IS_HEAD;
			hit_q   <= 1'b0;
			gt_q    <= 1'b0;
			off_q   <= '0;
			size_q  <= '0;
		end else begin
			unique case (act)
				ACT_HOLD: ;
				ACT_INIT: begin
					valid_q <= IS_HEAD;
					free_q  <= IS_HEAD;
					off_q   <= '0;
					size_q  <= budget;
				end
				ACT_MATCH: begin
					hit_q <= (func == FUNC_FREE) ? (valid_q && !free_q && off_q == ofs)
						: (valid_q && free_q && size_q >= req);
					gt_q  <= size_q > req;
				end
				ACT_TAKE_PREV: begin
					valid_q <= prev_flags.valid;
					free_q  <= prev_flags.free;
					off_q   <= prev_off;
					size_q  <= prev_size;
				end
				ACT_TAKE_NEXT: begin
					valid_q <= next_flags.valid;
					free_q  <= next_flags.free;
					off_q   <= next_off;
					size_q  <= next_size;
				end
				ACT_SPLIT_REM: begin
					valid_q <= 1'b1;
					free_q  <= 1'b1;
					off_q   <= rem_off[ADDR_BITS-1:0];
					size_q  <= prev_size - req;
				end
				ACT_ALLOC: begin
					free_q <= 1'b0;
					size_q <= req;
				end
				ACT_MARK_FREE: free_q <= 1'b1;
				ACT_ABSORB:    size_q <= size_q + next_size;
				default: ;
			endcase
		end
	end

	always_comb begin
		flags.valid = valid_q;
		flags.free  = free_q;
		flags.hit   = hit_q;
		flags.gt    = gt_q;
		flags.pair  = valid_q && free_q && next_flags.valid && next_flags.free;
	end
	assign off  = off_q;
	assign size = size_q;

endmodule
`default_nettype wire

// ===== sv/first_fit_block_allocator_top.sv =====
// first_fit_block_allocator_top: first-fit allocator over a chain of table cells.
// Uses ffba_pkg, ffba_req_if / ffba_rsp_if and ffba_cell.
//
// Usage: requests arrive on req (func 0 allocate req_size, func 1 free
// free_offset), one result beat per request leaves on rsp (alloc_offset,
// status, used_bytes). cfg_we with cfg_wdata writes the pool budget
// (saturated to 2^ADDR_BITS) and reinitializes the table to one free block;
// write only while no request is in flight.
// Each cell holds one block; all cells compare in parallel, a lowest-set-bit
// pick selects the first hit, and inserts or merges shift the chain by one
// cell per cycle.
// Steps: an allocate passes MATCH, ACT and DONE; a free that finds its block
// also passes MERGE, which absorbs one pair of adjacent free blocks at a
// time (at most 2 merges) until none is left, and then goes on to DONE.
// One request is in the chain at a time; the next is accepted once the
// previous result sits in the output register.
// Reset: one free block of size 0 at offset 0, used total 0, no result held.
// A stalled receiver holds the output beat; a finished request then waits
// for the output register before the next one is taken.
`default_nettype none
module first_fit_block_allocator_top #(
	parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF,
	parameter int ADDR_BITS  = ffba_pkg::ADDR_BITS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_we,
	input  wire logic [ADDR_BITS:0] cfg_wdata,
	ffba_req_if.sink            req,
	ffba_rsp_if.source          rsp
);
	import ffba_pkg::*;

	localparam int N = MAX_BLOCKS;

	cell_flags_t          flg [N];
	logic [ADDR_BITS-1:0] off [N];
	logic [ADDR_BITS:0]   sz  [N];
	logic [3:0]           act [N];

	logic [N-1:0] hit, gt, vld, pair;
	logic [N-1:0] first, fabove, firstp, pfirst, pabove;

	logic [2:0]           state_q;
	logic                 func_q;
	logic [ADDR_BITS:0]   req_q;
	logic [ADDR_BITS-1:0] ofs_q;
	logic [ADDR_BITS:0]   used_q;
	logic [ADDR_BITS:0]   budget;
	logic [ADDR_BITS-1:0] res_ofs_q;
	logic [1:0]           res_st_q;
	logic                 rsp_valid_q;
	logic [ADDR_BITS-1:0] rsp_ofs_q;
	logic [1:0]           rsp_st_q;
	logic [ADDR_BITS:0]   rsp_used_q;

	logic [ADDR_BITS-1:0] sel_off;
	logic [ADDR_BITS:0]   sel_size;
	logic                 nofit, split, full, do_alloc;

	assign budget = (cfg_wdata > ((ADDR_BITS+1)'(1) << ADDR_BITS))
		? ((ADDR_BITS+1)'(1) << ADDR_BITS) : cfg_wdata;

	genvar j;
	generate
		for (j = 0; j < N; j++) begin : g_cell
			cell_flags_t          pf, nf;
			logic [ADDR_BITS-1:0] po, no;
			logic [ADDR_BITS:0]   ps, ns;
			if (j == 0) begin : g_head
				assign pf = '0;
				assign po = '0;
				assign ps = '0;
			end else begin : g_mid
				assign pf = flg[j-1];
				assign po = off[j-1];
				assign ps = sz[j-1];
			end
			if (j == N-1) begin : g_tail
				assign nf = '0;
				assign no = '0;
				assign ns = '0;
			end else begin : g_body
				assign nf = flg[j+1];
				assign no = off[j+1];
				assign ns = sz[j+1];
			end

			assign hit[j]  = flg[j].hit;
			assign gt[j]   = flg[j].gt;
			assign vld[j]  = flg[j].valid;
			assign pair[j] = flg[j].pair;

			always_comb begin
				act[j] = ACT_HOLD;
				if (cfg_we) begin
					act[j] = ACT_INIT;
				end else begin
					unique case (state_q)
						S_MATCH: act[j] = ACT_MATCH;
						S_ACT: begin
							if (func_q == FUNC_FREE) begin
								if (first[j]) act[j] = ACT_MARK_FREE;
							end else if (do_alloc) begin
								priority if (first[j]) act[j] = ACT_ALLOC;
								else if (split && firstp[j]) act[j] = ACT_SPLIT_REM;
								else if (split && fabove[j]) act[j] = ACT_TAKE_PREV;
								else act[j] = ACT_HOLD;
							end
						end
						S_MERGE: begin
							priority if (pfirst[j]) act[j] = ACT_ABSORB;
							else if (pabove[j]) act[j] = ACT_TAKE_NEXT;
							else act[j] = ACT_HOLD;
						end
						default: act[j] = ACT_HOLD;
					endcase
				end
			end

			ffba_cell #(.ADDR_BITS(ADDR_BITS), .IS_HEAD(j == 0)) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.act        (act[j]),
				.func       (func_q),
				.req        (req_q),
				.ofs        (ofs_q),
				.budget     (budget),
				.prev_flags (pf),
				.prev_off   (po),
				.prev_size  (ps),
				.next_flags (nf),
				.next_off   (no),
				.next_size  (ns),
				.flags      (flg[j]),
				.off        (off[j]),
				.size       (sz[j])
			);
		end
	endgenerate

	assign first  = hit & (~hit + 1'b1);
	assign fabove = ~(first | (first - 1'b1));
	assign firstp = first << 1;
	assign pfirst = pair & (~pair + 1'b1);
	assign pabove = ~(pfirst | (pfirst - 1'b1));

	always_comb begin
		sel_off  = '0;
		sel_size = '0;
		for (int k = 0; k < N; k++) begin
			sel_off  = sel_off | (off[k] & {ADDR_BITS{first[k]}});
			sel_size = sel_size | (sz[k] & {(ADDR_BITS+1){first[k]}});
		end
	end

	assign nofit    = (req_q == '0) || !(|hit);
	assign split    = |(first & gt);
	assign full     = vld[N-1];
	assign do_alloc = !nofit && !(split && full);

	assign req.ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready) rsp_valid_q <= 1'b0;
			if (cfg_we) used_q <= '0;
			unique case (state_q)
				S_IDLE: if (req.valid) state_q <= S_MATCH;
				S_MATCH: state_q <= S_ACT;
				S_ACT: begin
					if (func_q == FUNC_FREE) begin
						if (!(|hit)) begin
							state_q <= S_DONE;
						end else begin
							used_q  <= used_q - sel_size;
							state_q <= S_MERGE;
						end
					end else begin
						if (do_alloc) used_q <= used_q + req_q;
						state_q <= S_DONE;
					end
				end
				S_MERGE: if (!(|pair)) state_q <= S_DONE;
				S_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			func_q <= req.func;
			req_q  <= req.req_size;
			ofs_q  <= req.free_offset;
		end
		if (state_q == S_ACT) begin
			res_ofs_q <= '0;
			res_st_q  <= ST_OK;
			if (func_q == FUNC_FREE) begin
				if (!(|hit)) res_st_q <= ST_NOTFOUND;
			end else if (nofit) begin
				res_st_q <= ST_NOFIT;
			end else if (split && full) begin
				res_st_q <= ST_FULL;
			end else begin
				res_ofs_q <= sel_off;
			end
		end
		if (state_q == S_DONE && (!rsp_valid_q || rsp.ready)) begin
			rsp_ofs_q  <= res_ofs_q;
			rsp_st_q   <= res_st_q;
			rsp_used_q <= used_q;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.alloc_offset = rsp_ofs_q;
	assign rsp.status       = rsp_st_q;
	assign rsp.used_bytes   = rsp_used_q;

	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n) vld[0])
		else $error("head cell lost its block");
	a_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		((vld >> 1) & ~vld) == '0)
		else $error("hole in the block chain");
	a_one_pick: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ACT |-> $onehot0(first))
		else $error("more than one cell picked");
	a_merged: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> pair == '0)
		else $error("adjacent free blocks left unmerged");

endmodule
`default_nettype wire
